/* hdl/sec_pkg.sv */
// Shared definitions for the scan elevator controller.
// Holds the cell command codes and the configuration register indexes.
// No dependencies.
package sec_pkg;

  // Command broadcast to every list cell in a cycle.
  typedef enum logic [2:0] {
    CMD_HOLD   = 3'b001,
    CMD_INSERT = 3'b010,
    CMD_REMOVE = 3'b100
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e cmd;
  } cell_ctrl_t;

  // Configuration port layout.
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_START_FLOOR = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_DIR   = 8'd1;

  // Operation codes carried on the input tuser.
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // Travel direction codes.
  localparam logic DIR_UP   = 1'b0;
  localparam logic DIR_DOWN = 1'b1;

endpackage

/* hdl/scan_elevator_controller_core.sv */
// Top level of the scan elevator controller: request streams, configuration
// port, car state and the chain of list cells. Depends on sec_pkg, sec_cell.
//
// Usage. Each request on the slave stream is either an add (tuser low),
// which inserts tdata's target floor into the sorted pending list, or a
// step (tuser high), which turns the car at the ends of the pending range,
// moves it one floor and serves a target on the floor it reaches. Every
// request yields exactly one result on the master stream, carrying the car
// floor, heading, pending count and the arrived, no-target and
// add-accepted flags.
// The result is valid in the cycle after acceptance, and one request is taken
// every cycle while the receiver keeps up. The rate is set by the list cells,
// which all compare against the key and shift together as a request is taken.
// The result sits in an output register; a new request is still taken while
// that register is being emptied in the same cycle, and when the receiver
// stalls the slave side stalls with it.
// Reset empties the list and puts the car on floor 0 heading up. A write to
// the start floor or start direction register places the car or sets its
// heading at once; the configuration port is ready whenever no request is
// being offered on the slave stream.
module scan_elevator_controller_core
  import sec_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = 16,
  parameter int unsigned FLOOR_BITS = 6
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Request stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [((FLOOR_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,  // dest_floor, zero fill
  input  logic                   s_axis_tuser,  // operation
  // Result stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [((FLOOR_BITS + $clog2(LIST_DEPTH + 1) + 4 + 7) / 8) * 8 - 1:0] m_axis_tdata,
                                                // floor_now, heading,
                                                // pending_count, arrived,
                                                // no_target, add_accepted,
                                                // zero fill
  // Configuration writes.
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned CountW   = $clog2(LIST_DEPTH + 1);
  localparam int unsigned IdxW     = $clog2(LIST_DEPTH);
  localparam int unsigned OutBits  = FLOOR_BITS + CountW + 4;
  localparam int unsigned OutDataW = ((OutBits + 7) / 8) * 8;

  localparam logic [CountW-1:0]     DepthC   = CountW'(LIST_DEPTH);
  localparam logic [FLOOR_BITS-1:0] TopFloor = {FLOOR_BITS{1'b1}};

  // Car state and list fill count.
  logic [FLOOR_BITS-1:0] car_q, car_d;
  logic                  dir_q, dir_d;
  logic [CountW-1:0]     cnt_q, cnt_d;

  // Output register.
  logic                  out_valid_q;
  logic [OutBits-1:0]    out_data_q, out_data_d;

  // Cell chain wiring.
  logic [FLOOR_BITS-1:0] ent   [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] gt_v;
  logic [LIST_DEPTH-1:0] match_v;
  cell_ctrl_t            ctrl;
  logic [FLOOR_BITS-1:0] key;

  logic                  accept;
  logic                  cfg_acc;
  logic                  op;
  logic [FLOOR_BITS-1:0] target;
  logic [CountW-1:0]     cnt_m1;
  logic [FLOOR_BITS-1:0] top_entry;
  logic                  step_dir;
  logic [FLOOR_BITS-1:0] next_floor;
  logic                  match_any;
  logic                  list_empty;
  logic                  add_ok;
  logic                  arrived;
  logic                  no_target;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = !s_axis_tvalid;
  assign cfg_acc       = cfg_valid_i && cfg_ready_o;

  assign op     = s_axis_tuser;
  assign target = s_axis_tdata[FLOOR_BITS-1:0];

  // Highest pending target sits in the last occupied cell.
  assign cnt_m1    = cnt_q - CountW'(1);
  assign top_entry = ent[cnt_m1[IdxW-1:0]];
  assign list_empty = (cnt_q == '0);

  // Direction choice at the ends of the pending range, then one floor of
  // travel, held at the bottom and top floors.
  always_comb begin
    step_dir = dir_q;
    if (car_q >= top_entry) begin
      step_dir = DIR_DOWN;
    end
    if (car_q <= ent[0]) begin
      step_dir = DIR_UP;
    end
    if (step_dir == DIR_UP) begin
      next_floor = (car_q == TopFloor) ? car_q : car_q + FLOOR_BITS'(1);
    end else begin
      next_floor = (car_q == '0) ? car_q : car_q - FLOOR_BITS'(1);
    end
  end

  // The cells compare against the new floor on a step and the target on an add.
  assign key       = (op == OP_STEP) ? next_floor : target;
  assign match_any = |match_v;
  assign add_ok    = !match_any && (cnt_q < DepthC);

  always_comb begin
    ctrl.cmd  = CMD_HOLD;
    car_d     = car_q;
    dir_d     = dir_q;
    cnt_d     = cnt_q;
    arrived   = 1'b0;
    no_target = 1'b0;
    if (accept) begin
      if (op == OP_ADD) begin
        if (add_ok) begin
          ctrl.cmd = CMD_INSERT;
          cnt_d    = cnt_q + CountW'(1);
        end
      end else if (list_empty) begin
        no_target = 1'b1;
      end else begin
        car_d = next_floor;
        dir_d = step_dir;
        if (match_any) begin
          ctrl.cmd = CMD_REMOVE;
          cnt_d    = cnt_q - CountW'(1);
          arrived  = 1'b1;
        end
      end
    end else if (cfg_acc) begin
      // A configuration write is only taken while no request is offered.
      if (cfg_index_i == CFG_START_FLOOR) begin
        car_d = cfg_data_i[FLOOR_BITS-1:0];
      end else if (cfg_index_i == CFG_START_DIR) begin
        dir_d = cfg_data_i[0];
      end
    end
    out_data_d = {(accept && (op == OP_ADD) && add_ok), no_target, arrived,
                  cnt_d, dir_d, car_d};
  end

  genvar gi;
  generate
    for (gi = 0; gi < LIST_DEPTH; gi++) begin : g_cell
      logic [FLOOR_BITS-1:0] left_entry;
      logic                  left_gt;
      logic [FLOOR_BITS-1:0] right_entry;
      if (gi == 0) begin : g_first
        assign left_entry = ent[gi];
        assign left_gt    = 1'b0;
      end else begin : g_inner_left
        assign left_entry = ent[gi-1];
        assign left_gt    = gt_v[gi-1];
      end
      if (gi == LIST_DEPTH - 1) begin : g_last
        assign right_entry = ent[gi];
      end else begin : g_inner_right
        assign right_entry = ent[gi+1];
      end
      sec_cell #(
        .FLOOR_BITS(FLOOR_BITS),
        .COUNT_BITS(CountW),
        .IDX       (gi)
      ) u_cell (
        .clk_i        (clk_i),
        .ctrl_i       (ctrl),
        .key_i        (key),
        .count_i      (cnt_q),
        .left_entry_i (left_entry),
        .left_gt_i    (left_gt),
        .right_entry_i(right_entry),
        .entry_o      (ent[gi]),
        .gt_o         (gt_v[gi]),
        .match_o      (match_v[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      car_q       <= '0;
      dir_q       <= DIR_UP;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      car_q <= car_d;
      dir_q <= dir_d;
      cnt_q <= cnt_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(out_data_q);

  // The fill count never passes the list depth.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthC)
    else $error("pending count beyond list depth");

  // A successful add grows the list by exactly one entry.
  a_add_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (op == OP_ADD) && add_ok) |=> (cnt_q == $past(cnt_q) + CountW'(1)))
    else $error("accepted add did not grow the list");

  // At most one of the three result flags is set.
  a_flags_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot0(out_data_q[OutBits-1:OutBits-3]))
    else $error("conflicting result flags");

  // The two lowest pending targets stay strictly ordered.
  a_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q >= CountW'(2)) |-> (ent[0] < ent[1]))
    else $error("target list lost its order");

endmodule

/* hdl/sec_cell.sv */
// One cell of the sorted target list: holds one floor entry and shifts it
// to or from its neighbours on insert and remove. Depends on sec_pkg.
module sec_cell
  import sec_pkg::*;
#(
  parameter int unsigned FLOOR_BITS = 6,
  parameter int unsigned COUNT_BITS = 5,
  parameter int unsigned IDX        = 0
) (
  input  logic                  clk_i,
  input  cell_ctrl_t            ctrl_i,
  input  logic [FLOOR_BITS-1:0] key_i,
  input  logic [COUNT_BITS-1:0] count_i,
  input  logic [FLOOR_BITS-1:0] left_entry_i,
  input  logic                  left_gt_i,
  input  logic [FLOOR_BITS-1:0] right_entry_i,
  output logic [FLOOR_BITS-1:0] entry_o,
  output logic                  gt_o,
  output logic                  match_o
);

  localparam logic [COUNT_BITS-1:0] IdxC = COUNT_BITS'(IDX);

  logic [FLOOR_BITS-1:0] entry_q, entry_d;
  logic                  occ;

  always_comb begin
    occ     = (IdxC < count_i);
    gt_o    = occ && (entry_q > key_i);
    match_o = occ && (entry_q == key_i);
    entry_d = entry_q;
    case (ctrl_i.cmd)
      CMD_INSERT: begin
        // Entries above the new floor move up one place; the first cell past the
        // smaller ones (a free slot if none is larger) takes the new floor.
        if (left_gt_i) begin
          entry_d = left_entry_i;
        end else if (gt_o || (IdxC == count_i)) begin
          entry_d = key_i;
        end
      end
      CMD_REMOVE: begin
        // The served entry and everything above it close up from the right.
        if (gt_o || match_o) begin
          entry_d = right_entry_i;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

/* tb/testbench.sv */
// Self-checking bench for scan_elevator_controller_core: random and directed
// add and step requests, a per-request scheduler predictor and a result checker.
// Depends on sec_pkg and the controller RTL.
module testbench;
  import sec_pkg::*;

  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned Depth    = 16;
  localparam logic [5:0]  TopFloor = 6'd63;
  localparam int unsigned StallLimit = 5000;

  // One request waiting to be driven; a drain entry holds the stream until
  // every outstanding result has come back.
  typedef struct {
    logic       op;
    logic [5:0] floor;
    bit         drain;
  } request_t;

  // Result fields in tdata order, lowest bit last.
  typedef struct packed {
    logic       add_accepted;
    logic       no_target;
    logic       arrived;
    logic [4:0] pending_count;
    logic       heading;
    logic [5:0] floor_now;
  } car_report_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [InDataW-1:0]     s_axis_tdata = '0;
  logic                   s_axis_tuser = OP_ADD;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OutDataW-1:0]    m_axis_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_START_FLOOR;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  request_t    stimulus_q[$];
  car_report_t report_q[$];

  // Predictor state.
  logic [5:0] car_floor = '0;
  logic       car_heading = DIR_UP;
  logic [5:0] targets[Depth];
  int         target_count = 0;

  int unsigned sender_idle_pct = 0;
  int unsigned receiver_idle_pct = 0;
  int unsigned failures = 0;
  int unsigned requests_taken = 0;
  int unsigned reports_checked = 0;
  int unsigned arrivals = 0;
  int unsigned rejected_adds = 0;
  int unsigned empty_steps = 0;
  int unsigned stall_cycles = 0;

  scan_elevator_controller_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // Applies one request to the predicted car and list and returns the report
  // that the controller should give for it.
  function automatic car_report_t advance_scheduler(input logic op, input logic [5:0] floor);
    car_report_t rep;
    int          pos;
    int          hit;
    rep = '0;
    hit = -1;
    if (op == OP_ADD) begin
      for (int i = 0; i < target_count; i++) begin
        if (targets[i] == floor) hit = i;
      end
      if (target_count < Depth && hit < 0) begin
        pos = target_count;
        while (pos > 0 && targets[pos-1] > floor) begin
          targets[pos] = targets[pos-1];
          pos--;
        end
        targets[pos] = floor;
        target_count++;
        rep.add_accepted = 1'b1;
      end
    end else if (target_count == 0) begin
      rep.no_target = 1'b1;
    end else begin
      // Turn at the ends of the pending range; turning up wins a tie.
      if (car_floor >= targets[target_count-1]) car_heading = DIR_DOWN;
      if (car_floor <= targets[0]) car_heading = DIR_UP;
      if (car_heading == DIR_UP) begin
        if (car_floor != TopFloor) car_floor++;
      end else if (car_floor != 6'd0) begin
        car_floor--;
      end
      for (int i = 0; i < target_count; i++) begin
        if (targets[i] == car_floor) hit = i;
      end
      if (hit >= 0) begin
        for (int i = hit; i + 1 < target_count; i++) targets[i] = targets[i+1];
        target_count--;
        rep.arrived = 1'b1;
      end
    end
    rep.floor_now = car_floor;
    rep.heading = car_heading;
    rep.pending_count = 5'(target_count);
    return rep;
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned seen);
    if (want != seen) begin
      failures++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
    end
  endtask

  // Request driver: a new request is presented only when the previous one
  // has been taken, so tvalid never drops while a request is pending.
  always @(posedge clk_i) begin : drive_requests
    request_t    nxt;
    car_report_t rep;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        rep = advance_scheduler(s_axis_tuser, s_axis_tdata[5:0]);
        if (s_axis_tuser == OP_ADD && !rep.add_accepted && rep.pending_count == 5'(Depth))
          rejected_adds++;
        report_q.push_back(rep);
        requests_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (stimulus_q.size() > 0 && stimulus_q[0].drain && report_q.size() == 0) begin
          void'(stimulus_q.pop_front());
        end
        if (stimulus_q.size() > 0 && !stimulus_q[0].drain &&
            $urandom_range(0, 99) >= sender_idle_pct) begin
          nxt = stimulus_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= nxt.op;
          s_axis_tdata <= {2'b00, nxt.floor};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result checker: each report taken is matched against the oldest one
  // predicted.
  always @(posedge clk_i) begin : check_reports
    car_report_t seen;
    car_report_t want;
    if (rst_ni) begin
      m_axis_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        seen = m_axis_tdata[14:0];
        if (report_q.size() == 0) begin
          failures++;
          $display("%0t: unexpected result, expected none, actual %h", $time, seen);
        end else begin
          want = report_q.pop_front();
          compare_field("floor_now", want.floor_now, seen.floor_now);
          compare_field("heading", want.heading, seen.heading);
          compare_field("pending_count", want.pending_count, seen.pending_count);
          compare_field("arrived", want.arrived, seen.arrived);
          compare_field("no_target", want.no_target, seen.no_target);
          compare_field("add_accepted", want.add_accepted, seen.add_accepted);
          reports_checked++;
          if (want.arrived) arrivals++;
          if (want.no_target) empty_steps++;
        end
      end
    end
  end

  // Watchdog on cycles in which no handshake of any kind completes.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Configuration write; also updates the predicted car at the handshake.
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!(cfg_valid && cfg_ready));
    if (idx == CFG_START_FLOOR) car_floor = val[5:0];
    else if (idx == CFG_START_DIR) car_heading = val[0];
    cfg_valid <= 1'b0;
  endtask

  task automatic push_request(input logic op, input logic [5:0] floor);
    request_t r;
    r.op = op;
    r.floor = floor;
    r.drain = 1'b0;
    stimulus_q.push_back(r);
  endtask

  // Sampled away from the rising edge so that the driver's updates have settled.
  task automatic wait_until_quiet();
    while (stimulus_q.size() > 0 || report_q.size() > 0 || s_axis_tvalid)
      @(negedge clk_i);
  endtask

  initial begin : run_phases
    request_t    hold;
    int unsigned step_pct;
    logic [5:0]  floor;
    hold.op = OP_ADD;
    hold.floor = '0;
    hold.drain = 1'b1;
    for (int i = 0; i < Depth; i++) targets[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    sender_idle_pct = 19;
    receiver_idle_pct = 67;
    // Wide write: only the low six bits reach the car.
    write_register(CFG_START_FLOOR, 8'hFF);
    write_register(CFG_START_DIR, 8'(DIR_DOWN));

    // Directed part: empty step, target on the car floor, duplicate, top-floor
    // saturation with both turning rules true, then filling and overfilling.
    push_request(OP_STEP, 6'd21);
    push_request(OP_ADD, TopFloor);
    push_request(OP_ADD, TopFloor);
    push_request(OP_STEP, 6'd42);
    push_request(OP_STEP, 6'd0);
    push_request(OP_ADD, 6'd0);
    push_request(OP_STEP, TopFloor);
    for (int i = 1; i < Depth; i++) push_request(OP_ADD, 6'(i * 4));
    push_request(OP_ADD, 6'd61);
    push_request(OP_ADD, 6'd0);
    wait_until_quiet();

    for (int phase = 1; phase <= 6; phase++) begin
      sender_idle_pct = (phase <= 2) ? 19 : (phase <= 4) ? 67 : 0;
      receiver_idle_pct = (phase <= 2) ? 67 : (phase <= 4) ? 19 : 0;
      write_register(CFG_START_FLOOR, (phase == 1) ? 8'd0 :
                                      (phase == 2) ? 8'd63 : 8'($urandom_range(0, 63)));
      write_register(CFG_START_DIR, (phase % 2 == 0) ? 8'(DIR_DOWN) : 8'(DIR_UP));
      step_pct = 50;
      for (int n = 0; n < 333; n++) begin
        // Every 40 requests a new random step share is drawn.
        if (n % 40 == 0) step_pct = 25 * $urandom_range(1, 3);
        if (n == 160) stimulus_q.push_back(hold);
        case ($urandom_range(0, 7))
          0:       floor = $urandom_range(0, 1) ? TopFloor : 6'd0;
          1, 2:    floor = 6'($urandom_range(0, 7));
          default: floor = 6'($urandom_range(0, 63));
        endcase
        push_request(($urandom_range(0, 99) < step_pct) ? OP_STEP : OP_ADD, floor);
      end
      wait_until_quiet();
    end

    repeat (5) @(posedge clk_i);
    $display("Drove %0d requests, checked %0d results over seven configurations.",
             requests_taken, reports_checked);
    $display("Served %0d targets; %0d empty-list steps, %0d adds refused on a full list.",
             arrivals, empty_steps, rejected_adds);
    if (failures == 0 && report_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
